@@ src/box_downscale_rgb565_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Box downscaler assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSCALE_RGB565_UNIT_DEFINES_SVH
`define BOX_DOWNSCALE_RGB565_UNIT_DEFINES_SVH

// checked only while out of reset
`define BDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BDS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/bds_pkg.sv @@
// ----------------------------------------------------------------------------
// Box downscaler package
// Constants, register codes and state types shared by the block.
// ----------------------------------------------------------------------------
package bds_pkg;

	localparam int SUM_W     = 28;
	localparam int CH_W      = 8;
	localparam int DST_H_CAP = 256;
	localparam int IDX_W     = 3;
	localparam int CFG_W     = 11;

	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_UPD  = 2'b10
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_OUT  = 3'b100
	} back_state_t;

endpackage

@@ src/bds_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bds_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/bds_queue.sv @@
// ----------------------------------------------------------------------------
// Box downscaler result queue
// Two-entry FIFO between the accumulate front and the divide back.
// ----------------------------------------------------------------------------
module bds_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] entry_q [2];
	logic         wptr_q, rptr_q;
	logic [1:0]   cnt_q;
	logic         do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = entry_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

@@ src/bds_front.sv @@
// ----------------------------------------------------------------------------
// Box downscaler front
// Accepts source pixels, tracks box edges, accumulates column sums.
// ----------------------------------------------------------------------------
module bds_front #(
	parameter int MAX_DST_WIDTH = 256,
	parameter int SW_W          = 11,
	parameter int QW            = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  restart,
	input  logic [SW_W-1:0]       sw,
	input  logic [SW_W-1:0]       sh,
	input  logic [SW_W-1:0]       dw,
	input  logic [SW_W-1:0]       dh,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [23:0]           in_pixel,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [QW-1:0]         push_data
);

	localparam int AW    = $clog2(MAX_DST_WIDTH);
	localparam int EW    = SW_W + 1;
	localparam int CNT_W = 2 * SW_W;
	localparam int RW    = 3 * bds_pkg::SUM_W;

	bds_pkg::front_state_t state_q;
	logic                  pend_q;
	logic [23:0]           px_s1;
	logic [SW_W-1:0]       sc_q, sr_q, x_q, y_q, band_q, prev_q;
	logic [EW-1:0]         ec_q, er_q;
	logic [RW-1:0]         rd_data, wr_data;
	logic [bds_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
	logic                  first_row, col_hit, row_hit, need_push, go, row_end;
	logic [SW_W-1:0]       colw, rowh, sc_nx, sr_nx, y_nx;
	logic [CNT_W-1:0]      count;
	logic                  done;

	assign in_ready = (state_q == bds_pkg::F_IDLE) && !pend_q;

	bds_ram #(.W(RW), .DEPTH(MAX_DST_WIDTH)) u_sums (
		.clk   (clk),
		.we    (go),
		.waddr (AW'(x_q)),
		.wdata (wr_data),
		.raddr (AW'(x_q)),
		.rdata (rd_data)
	);

	always_comb begin
		first_row = (sr_q == band_q);
		sum_r = first_row ? bds_pkg::SUM_W'(px_s1[7:0])
		                  : rd_data[27:0] + bds_pkg::SUM_W'(px_s1[7:0]);
		sum_g = first_row ? bds_pkg::SUM_W'(px_s1[15:8])
		                  : rd_data[55:28] + bds_pkg::SUM_W'(px_s1[15:8]);
		sum_b = first_row ? bds_pkg::SUM_W'(px_s1[23:16])
		                  : rd_data[83:56] + bds_pkg::SUM_W'(px_s1[23:16]);
		wr_data = {sum_b, sum_g, sum_r};
		// edge error terms: hit while below the destination size
		col_hit = (ec_q < EW'(dw));
		row_hit = (er_q < EW'(dh));
		sc_nx   = sc_q + 1'b1;
		sr_nx   = sr_q + 1'b1;
		y_nx    = y_q + 1'b1;
		colw    = sc_nx - prev_q;
		rowh    = sr_nx - band_q;
		count   = CNT_W'(colw) * CNT_W'(rowh);
		done    = (x_q + 1'b1 == dw) && (y_nx == dh);
		row_end = (sc_nx == sw);
		need_push = col_hit && row_hit;
		go = (state_q == bds_pkg::F_UPD) && (!need_push || push_ready);
	end

	assign push_valid = (state_q == bds_pkg::F_UPD) && need_push;
	assign push_data  = {done, 8'(y_q), 8'(x_q), count, sum_b, sum_g, sum_r};

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_s1 <= in_pixel;
		end
	end

	// reload stays pending until the front is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b1;
		end else begin
			pend_q <= restart || (pend_q && state_q != bds_pkg::F_IDLE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bds_pkg::F_IDLE;
			sc_q    <= '0;
			sr_q    <= '0;
			x_q     <= '0;
			y_q     <= '0;
			band_q  <= '0;
			prev_q  <= '0;
			ec_q    <= '0;
			er_q    <= '0;
		end else begin
			unique case (state_q)
				bds_pkg::F_IDLE: begin
					if (pend_q) begin
						sc_q   <= '0;
						sr_q   <= '0;
						x_q    <= '0;
						y_q    <= '0;
						band_q <= '0;
						prev_q <= '0;
						ec_q   <= EW'(sw) - EW'(dw);
						er_q   <= EW'(sh) - EW'(dh);
					end else if (in_valid) begin
						state_q <= bds_pkg::F_UPD;
					end
				end
				bds_pkg::F_UPD: begin
					if (go) begin
						state_q <= bds_pkg::F_IDLE;
						if (row_end) begin
							sc_q   <= '0;
							x_q    <= '0;
							prev_q <= '0;
							ec_q   <= EW'(sw) - EW'(dw);
							if (row_hit) begin
								if (sr_nx >= sh || y_nx >= dh) begin
									sr_q   <= '0;
									y_q    <= '0;
									band_q <= '0;
									er_q   <= EW'(sh) - EW'(dh);
								end else begin
									sr_q   <= sr_nx;
									y_q    <= y_nx;
									band_q <= sr_nx;
									er_q   <= er_q + EW'(sh) - EW'(dh);
								end
							end else begin
								sr_q <= sr_nx;
								er_q <= er_q - EW'(dh);
							end
						end else begin
							sc_q <= sc_nx;
							if (col_hit) begin
								x_q    <= x_q + 1'b1;
								prev_q <= sc_nx;
								ec_q   <= ec_q + EW'(sw) - EW'(dw);
							end else begin
								ec_q <= ec_q - EW'(dw);
							end
						end
					end
				end
				default: state_q <= bds_pkg::F_IDLE;
			endcase
		end
	end

endmodule

@@ src/bds_back.sv @@
// ----------------------------------------------------------------------------
// Box downscaler back
// Divides the three channel sums by the box count, packs RGB565.
// ----------------------------------------------------------------------------
module bds_back #(
	parameter int CNT_W = 22,
	parameter int QW    = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  logic [QW-1:0] pop_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   out_data,
	output logic          out_last
);

	localparam int SW = bds_pkg::SUM_W;
	localparam int STEP_W = $clog2(SW);

	bds_pkg::back_state_t state_q;
	logic [SW-1:0]     dq_r_q, dq_g_q, dq_b_q;
	logic [CNT_W-1:0]  rem_r_q, rem_g_q, rem_b_q, div_q;
	logic [STEP_W-1:0] step_q;
	logic [7:0]        col_q, row_q;
	logic              last_q;
	logic [CNT_W:0]    sh_r, sh_g, sh_b;
	logic              ge_r, ge_g, ge_b;

	assign pop_ready = (state_q == bds_pkg::B_IDLE);
	assign out_valid = (state_q == bds_pkg::B_OUT);
	assign out_last  = last_q;
	assign out_data  = {row_q, col_q, dq_r_q[7:3], dq_g_q[7:2], dq_b_q[7:3]};

	always_comb begin
		sh_r = {rem_r_q, dq_r_q[SW-1]};
		sh_g = {rem_g_q, dq_g_q[SW-1]};
		sh_b = {rem_b_q, dq_b_q[SW-1]};
		ge_r = (sh_r >= (CNT_W+1)'(div_q));
		ge_g = (sh_g >= (CNT_W+1)'(div_q));
		ge_b = (sh_b >= (CNT_W+1)'(div_q));
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bds_pkg::B_IDLE: begin
				dq_r_q  <= pop_data[SW-1:0];
				dq_g_q  <= pop_data[2*SW-1:SW];
				dq_b_q  <= pop_data[3*SW-1:2*SW];
				div_q   <= pop_data[3*SW+CNT_W-1:3*SW];
				col_q   <= pop_data[3*SW+CNT_W+7:3*SW+CNT_W];
				row_q   <= pop_data[3*SW+CNT_W+15:3*SW+CNT_W+8];
				last_q  <= pop_data[3*SW+CNT_W+16];
				rem_r_q <= '0;
				rem_g_q <= '0;
				rem_b_q <= '0;
			end
			bds_pkg::B_DIV: begin
				// one restoring step per cycle on each channel
				rem_r_q <= ge_r ? CNT_W'(sh_r - (CNT_W+1)'(div_q)) : CNT_W'(sh_r);
				rem_g_q <= ge_g ? CNT_W'(sh_g - (CNT_W+1)'(div_q)) : CNT_W'(sh_g);
				rem_b_q <= ge_b ? CNT_W'(sh_b - (CNT_W+1)'(div_q)) : CNT_W'(sh_b);
				dq_r_q  <= {dq_r_q[SW-2:0], ge_r};
				dq_g_q  <= {dq_g_q[SW-2:0], ge_g};
				dq_b_q  <= {dq_b_q[SW-2:0], ge_b};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bds_pkg::B_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				bds_pkg::B_IDLE: begin
					step_q <= '0;
					if (pop_valid) state_q <= bds_pkg::B_DIV;
				end
				bds_pkg::B_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SW - 1)) state_q <= bds_pkg::B_OUT;
				end
				bds_pkg::B_OUT: begin
					if (out_ready) state_q <= bds_pkg::B_IDLE;
				end
				default: state_q <= bds_pkg::B_IDLE;
			endcase
		end
	end

endmodule

@@ src/box_downscale_rgb565_unit.sv @@
// In the accumulate front a source pixel passes the RAM read, then the update.
// The front takes no new source pixel until the read-modify-write of the sum RAM is done;
// a pixel that closes a box stalls while the two-entry result queue is full.
// In the back a box result passes load, the 28-step restoring divider, then output.
// Reset, or a write to a valid register index, restarts the frame; the front reloads its
// edge trackers from a registered restart flag before accepting. Size registers reset to 1.
// ----------------------------------------------------------------------------
// Box downscaler, RGB888 to RGB565
// Box-filter averaging of raster source pixels into a destination no larger than the source.
// ----------------------------------------------------------------------------
`include "box_downscale_rgb565_unit_defines.svh"

module box_downscale_rgb565_unit #(
	parameter int MAX_SRC_DIM   = 1024,
	parameter int MAX_DST_WIDTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bds_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bds_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [23:0]                 s_axis_tdata,  // red_in, green_in, blue_in
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,  // pixel_565, dest_column, dest_row
	output logic                        m_axis_tlast   // frame_done
);

	localparam int SW_W  = $clog2(MAX_SRC_DIM + 1);
	localparam int CNT_W = 2 * SW_W;
	localparam int QW    = 3 * bds_pkg::SUM_W + CNT_W + 17;

	logic [10:0]     src_width_q, src_height_q;
	logic [8:0]      dst_width_q, dst_height_q;
	logic [12:0]     t_sw, t_sh, t_dw, t_dh;
	logic [SW_W-1:0] sw, sh, dw, dh;
	logic            restart;
	logic            push_valid, push_ready, pop_valid, pop_ready;
	logic [QW-1:0]   push_data, pop_data;

	assign restart = cfg_we && (cfg_index == bds_pkg::REG_SRC_WIDTH ||
		cfg_index == bds_pkg::REG_SRC_HEIGHT || cfg_index == bds_pkg::REG_DST_WIDTH ||
		cfg_index == bds_pkg::REG_DST_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 11'd1;
			src_height_q <= 11'd1;
			dst_width_q  <= 9'd1;
			dst_height_q <= 9'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bds_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				bds_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				bds_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_data[8:0];
				bds_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// effective sizes: zero acts as one, saturate, no upscaling
	always_comb begin
		t_sw = (src_width_q == 11'd0) ? 13'd1 : 13'(src_width_q);
		if (t_sw > 13'(MAX_SRC_DIM)) t_sw = 13'(MAX_SRC_DIM);
		t_sh = (src_height_q == 11'd0) ? 13'd1 : 13'(src_height_q);
		if (t_sh > 13'(MAX_SRC_DIM)) t_sh = 13'(MAX_SRC_DIM);
		t_dw = (dst_width_q == 9'd0) ? 13'd1 : 13'(dst_width_q);
		if (t_dw > 13'(MAX_DST_WIDTH)) t_dw = 13'(MAX_DST_WIDTH);
		if (t_dw > t_sw) t_dw = t_sw;
		t_dh = (dst_height_q == 9'd0) ? 13'd1 : 13'(dst_height_q);
		if (t_dh > 13'(bds_pkg::DST_H_CAP)) t_dh = 13'(bds_pkg::DST_H_CAP);
		if (t_dh > t_sh) t_dh = t_sh;
		sw = SW_W'(t_sw);
		sh = SW_W'(t_sh);
		dw = SW_W'(t_dw);
		dh = SW_W'(t_dh);
	end

	bds_front #(
		.MAX_DST_WIDTH (MAX_DST_WIDTH),
		.SW_W          (SW_W),
		.QW            (QW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.sw         (sw),
		.sh         (sh),
		.dw         (dw),
		.dh         (dh),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_pixel   (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	bds_queue #(.W(QW)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	bds_back #(.CNT_W(CNT_W), .QW(QW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	`BDS_ASSERT(a_last_col, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[23:16] == 8'(dw - 1'b1), "frame end not on last column")
	`BDS_ASSERT(a_restart_blocks, $past(restart) |-> !s_axis_tready, "pixel taken during frame restart")
	`BDS_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_axis_tvalid && !s_axis_tready, "handshake active in reset")

endmodule
